FILE: design/bml_pkg.sv
// package for the bicycle model linearizer: cordic constants, arctangent table,
// register codes and the per-beat sideband record. no dependencies
`default_nettype none

package bml_pkg;

    localparam int CORDIC_STEPS   = 28;
    localparam int ITER_PER_STAGE = 2;
    localparam int CORDIC_STAGES  = CORDIC_STEPS / ITER_PER_STAGE;

    localparam logic [28:0]        HALF_PI_Q28  = 29'd421657428;
    localparam logic signed [33:0] INV_GAIN_Q30 = 34'sd652032874;

    // register index codes (byte address bit 2)
    localparam logic REG_WHEELBASE   = 1'b0;
    localparam logic REG_STEER_LIMIT = 1'b1;

    localparam logic [31:0] WHEELBASE_RST   = 32'd46808350;
    localparam logic [28:0] STEER_LIMIT_RST = 29'd171798692;

    // atan(2^-i) in q4.28, rounded to nearest
    function automatic logic [27:0] atan_q28(input int unsigned idx);
        logic [27:0] v;
        case (idx)
            0:  v = 28'd210828714;
            1:  v = 28'd124459457;
            2:  v = 28'd65760959;
            3:  v = 28'd33381290;
            4:  v = 28'd16755422;
            5:  v = 28'd8385879;
            6:  v = 28'd4193963;
            7:  v = 28'd2097109;
            8:  v = 28'd1048571;
            9:  v = 28'd524287;
            10: v = 28'd262144;
            11: v = 28'd131072;
            12: v = 28'd65536;
            13: v = 28'd32768;
            14: v = 28'd16384;
            15: v = 28'd8192;
            16: v = 28'd4096;
            17: v = 28'd2048;
            18: v = 28'd1024;
            19: v = 28'd512;
            20: v = 28'd256;
            21: v = 28'd128;
            22: v = 28'd64;
            23: v = 28'd32;
            24: v = 28'd16;
            25: v = 28'd8;
            26: v = 28'd4;
            27: v = 28'd2;
            default: v = 28'd0;
        endcase
        return v;
    endfunction

    // sideband that rides along the pipeline with each beat
    typedef struct packed {
        logic        neg;     // curvature sign
        logic [31:0] ds;      // step length
        logic        azero;   // product was zero
        logic [29:0] raw;
        logic [29:0] th;
        logic [28:0] thm;
        logic        flag;
        logic        dzero;   // denominator zero
        logic        govf;    // gain quotient >= 2^32
        logic        oovf;    // offset quotient >= 2^32
        logic        nnz;     // offset numerator nonzero
    } item_t;

endpackage

`default_nettype wire

FILE: design/bml_divider.sv
// pipelined restoring divider, a fixed number of quotient bits per stage
// expects rem_in < den; no package dependency
`default_nettype none

module bml_divider #(
    parameter int DW  = 64,
    parameter int QW  = 32,
    parameter int SPS = 2
) (
    input  wire logic          aclk,
    input  wire logic          ce,
    input  wire logic [DW-1:0] den,
    input  wire logic [DW-1:0] rem_in,
    input  wire logic [QW-1:0] low_in,
    output logic      [QW-1:0] quot
);

    localparam int NS = QW / SPS;

    logic [DW-1:0] den_reg [0:NS-1];
    logic [DW-1:0] rem_reg [0:NS-1];
    logic [QW-1:0] low_reg [0:NS-1];
    logic [QW-1:0] q_reg   [0:NS-1];
    logic [DW-1:0] rem_next [0:NS-1];
    logic [QW-1:0] low_next [0:NS-1];
    logic [QW-1:0] q_next   [0:NS-1];

    genvar s;
    generate
        for (s = 0; s < NS; s++) begin : g_stage
            logic [DW-1:0] d_src;
            logic [DW-1:0] r_src;
            logic [QW-1:0] l_src;
            logic [QW-1:0] q_src;

            if (s == 0) begin : g_first
                assign d_src = den;
                assign r_src = rem_in;
                assign l_src = low_in;
                assign q_src = '0;
            end else begin : g_next
                assign d_src = den_reg[s-1];
                assign r_src = rem_reg[s-1];
                assign l_src = low_reg[s-1];
                assign q_src = q_reg[s-1];
            end

            always_comb begin
                logic [DW:0]   t;
                logic [DW-1:0] r;
                logic [QW-1:0] l;
                logic [QW-1:0] q;
                r = r_src;
                l = l_src;
                q = q_src;
                for (int j = 0; j < SPS; j++) begin
                    t = {r, l[QW-1]};
                    l = {l[QW-2:0], 1'b0};
                    if (t >= {1'b0, d_src}) begin
                        r = DW'(t - {1'b0, d_src});
                        q = {q[QW-2:0], 1'b1};
                    end else begin
                        r = t[DW-1:0];
                        q = {q[QW-2:0], 1'b0};
                    end
                end
                rem_next[s] = r;
                low_next[s] = l;
                q_next[s]   = q;
            end

            always_ff @(posedge aclk) begin
                if (ce) begin
                    den_reg[s] <= d_src;
                    rem_reg[s] <= rem_next[s];
                    low_reg[s] <= low_next[s];
                    q_reg[s]   <= q_next[s];
                end
            end
        end
    endgenerate

    assign quot = q_reg[NS-1];

endmodule

`default_nettype wire

FILE: design/bicycle_model_linearizer_top.sv
// throughput one beat per cycle unless the output beat is not taken
// every stage is a register slice with its own valid bit
// the whole pipe advances together and holds when the output beat is not taken
// aresetn is synchronous, active low: clears valid bits and loads the register defaults
// depends on bml_pkg and bml_divider
`default_nettype none

module bicycle_model_linearizer_top
    import bml_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // apb register port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,   // curvature[31:0], step_length[63:32]
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [127:0] m_tdata,   // steer_ref_raw[29:0], steer_ref_clamped[59:30],
                                         // input_gain[91:60], offset_term[123:92], zero pad
    output logic      [0:0]   m_tuser    // was_clamped[0]
);

    // stage map
    localparam int NORM_ST    = 1;
    localparam int ATAN_ST    = 2;
    localparam int CLAMP_ST   = ATAN_ST + CORDIC_STAGES;
    localparam int COS_ST     = CLAMP_ST + 1;
    localparam int SQ_ST      = COS_ST + CORDIC_STAGES;
    localparam int MUL_ST     = SQ_ST + 1;
    localparam int PREP_ST    = MUL_ST + 1;
    localparam int DIV_ST     = PREP_ST + 1;
    localparam int DIV_SPS    = 2;
    localparam int DIV_STAGES = 32 / DIV_SPS;
    localparam int OUT_ST     = DIV_ST + DIV_STAGES;
    localparam int LAT        = OUT_ST + 1;

    // ------------------------------------------------------------------
    // config registers
    // ------------------------------------------------------------------
    logic [31:0] wheelbase_reg;
    logic [28:0] steer_limit_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wheelbase_reg   <= WHEELBASE_RST;
            steer_limit_reg <= STEER_LIMIT_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_WHEELBASE:   wheelbase_reg   <= pwdata;
                REG_STEER_LIMIT: steer_limit_reg <= pwdata[28:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WHEELBASE:   prdata = wheelbase_reg;
            REG_STEER_LIMIT: prdata = {3'b000, steer_limit_reg};
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipe control: everything moves when the output slot is free or taken
    // ------------------------------------------------------------------
    logic           ce;
    logic [LAT-1:0] v_reg;

    assign ce       = ~v_reg[OUT_ST] | m_tready;
    assign s_tready = ce;
    assign m_tvalid = v_reg[OUT_ST];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= {v_reg[LAT-2:0], s_tvalid};
        end
    end

    // sideband per stage
    item_t itm_reg  [0:OUT_ST-1];
    item_t itm_next [0:OUT_ST-1];

    // ------------------------------------------------------------------
    // stage 0: |curvature| and wheelbase * |curvature| (q12.52)
    // ------------------------------------------------------------------
    logic [31:0] cu;
    logic [31:0] cmag;
    logic [63:0] prod_reg;
    logic [63:0] prod_next;

    assign cu        = s_tdata[31:0];
    assign cmag      = cu[31] ? (~cu + 32'd1) : cu;
    assign prod_next = 64'(wheelbase_reg) * 64'(cmag);

    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_reg <= prod_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: normalize (1.0, a) so the larger lands in [2^59, 2^60)
    // only bits 63..52 matter, below that 1.0 is the larger operand
    // ------------------------------------------------------------------
    logic signed [62:0] ax_reg  [0:CORDIC_STAGES];
    logic signed [62:0] ay_reg  [0:CORDIC_STAGES];
    logic signed [31:0] az_reg  [0:CORDIC_STAGES];
    logic signed [62:0] ax_next [0:CORDIC_STAGES];
    logic signed [62:0] ay_next [0:CORDIC_STAGES];
    logic signed [31:0] az_next [0:CORDIC_STAGES];

    logic [3:0]  msb_pos;
    logic        msb_hit;
    logic [2:0]  lsh;
    logic [2:0]  rsh;
    logic [63:0] ux;
    logic [63:0] uy;

    always_comb begin
        msb_pos = '0;
        msb_hit = 1'b0;
        for (int b = 0; b < 12; b++) begin
            if (prod_reg[52 + b]) begin
                msb_pos = 4'(b);
                msb_hit = 1'b1;
            end
        end
        if (!msb_hit) begin
            lsh = 3'd7;
            rsh = 3'd0;
        end else if (msb_pos <= 4'd7) begin
            lsh = 3'(4'd7 - msb_pos);
            rsh = 3'd0;
        end else begin
            lsh = 3'd0;
            rsh = 3'(msb_pos - 4'd7);
        end
        ux = ((64'd1 << 52) << lsh) >> rsh;
        uy = (prod_reg << lsh) >> rsh;
        ax_next[0] = $signed(ux[62:0]);
        ay_next[0] = $signed(uy[62:0]);
        az_next[0] = '0;
    end

    // ------------------------------------------------------------------
    // stages 2..15: vectoring cordic, two micro-rotations a stage
    // ------------------------------------------------------------------
    genvar s;
    generate
        for (s = 1; s <= CORDIC_STAGES; s++) begin : g_atan
            localparam int IT = (s - 1) * ITER_PER_STAGE;
            always_comb begin
                logic signed [62:0] x;
                logic signed [62:0] y;
                logic signed [62:0] t;
                logic signed [31:0] z;
                x = ax_reg[s-1];
                y = ay_reg[s-1];
                z = az_reg[s-1];
                for (int j = 0; j < ITER_PER_STAGE; j++) begin
                    if (y >= 0) begin
                        t = x + (y >>> (IT + j));
                        y = y - (x >>> (IT + j));
                        z = z + $signed({4'b0000, atan_q28(IT + j)});
                    end else begin
                        t = x - (y >>> (IT + j));
                        y = y + (x >>> (IT + j));
                        z = z - $signed({4'b0000, atan_q28(IT + j)});
                    end
                    x = t;
                end
                ax_next[s] = x;
                ay_next[s] = y;
                az_next[s] = z;
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k <= CORDIC_STAGES; k++) begin
                ax_reg[k] <= ax_next[k];
                ay_reg[k] <= ay_next[k];
                az_reg[k] <= az_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // clamp stage: limit to [0, pi/2], apply sign, steering limit clamp
    // clamp also fires when the angle equals the limit
    // ------------------------------------------------------------------
    logic signed [31:0] za;
    logic [28:0]        zm;
    logic               cl_flag;
    logic [28:0]        cl_thm;
    logic [29:0]        cl_raw;
    logic [29:0]        cl_th;
    item_t              cl_in;

    assign cl_in = itm_reg[CLAMP_ST-1];
    assign za    = az_reg[CORDIC_STAGES];

    always_comb begin
        if (cl_in.azero || za < 0) begin
            zm = '0;
        end else if (za > $signed({3'b000, HALF_PI_Q28})) begin
            zm = HALF_PI_Q28;
        end else begin
            zm = za[28:0];
        end
        cl_flag = zm >= steer_limit_reg;
        cl_thm  = cl_flag ? steer_limit_reg : zm;
        cl_raw  = cl_in.neg ? (30'd0 - {1'b0, zm}) : {1'b0, zm};
        cl_th   = cl_in.neg ? (30'd0 - {1'b0, cl_thm}) : {1'b0, cl_thm};
    end

    // ------------------------------------------------------------------
    // cos stages: rotation cordic on the clamped angle, q2.30
    // ------------------------------------------------------------------
    logic signed [33:0] cx_reg  [0:CORDIC_STAGES];
    logic signed [33:0] cy_reg  [0:CORDIC_STAGES];
    logic signed [31:0] cz_reg  [0:CORDIC_STAGES];
    logic signed [33:0] cx_next [0:CORDIC_STAGES];
    logic signed [33:0] cy_next [0:CORDIC_STAGES];
    logic signed [31:0] cz_next [0:CORDIC_STAGES];

    assign cx_next[0] = INV_GAIN_Q30;
    assign cy_next[0] = '0;
    assign cz_next[0] = $signed({{2{cl_th[29]}}, cl_th});

    generate
        for (s = 1; s <= CORDIC_STAGES; s++) begin : g_cos
            localparam int IT = (s - 1) * ITER_PER_STAGE;
            always_comb begin
                logic signed [33:0] x;
                logic signed [33:0] y;
                logic signed [33:0] t;
                logic signed [31:0] z;
                x = cx_reg[s-1];
                y = cy_reg[s-1];
                z = cz_reg[s-1];
                for (int j = 0; j < ITER_PER_STAGE; j++) begin
                    if (z >= 0) begin
                        t = x - (y >>> (IT + j));
                        y = y + (x >>> (IT + j));
                        z = z - $signed({4'b0000, atan_q28(IT + j)});
                    end else begin
                        t = x + (y >>> (IT + j));
                        y = y - (x >>> (IT + j));
                        z = z + $signed({4'b0000, atan_q28(IT + j)});
                    end
                    x = t;
                end
                cx_next[s] = x;
                cy_next[s] = y;
                cz_next[s] = z;
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k <= CORDIC_STAGES; k++) begin
                cx_reg[k] <= cx_next[k];
                cy_reg[k] <= cy_next[k];
                cz_reg[k] <= cz_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // square stage: cc = cos^2 truncated to q2.30
    // ------------------------------------------------------------------
    logic signed [33:0] cfin;
    logic [32:0]        cm;
    logic [65:0]        sq;
    logic [31:0]        cc_reg;

    assign cfin = cx_reg[CORDIC_STAGES];
    assign cm   = cfin[33] ? 33'(-cfin) : cfin[32:0];
    assign sq   = 66'(cm) * 66'(cm);

    always_ff @(posedge aclk) begin
        if (ce) begin
            cc_reg <= sq[61:30];
        end
    end

    // ------------------------------------------------------------------
    // multiply stage: denominator d = wheelbase*cc, numerator n = ds*thm
    // ------------------------------------------------------------------
    logic [63:0] d_reg;
    logic [60:0] n_reg;
    item_t       mul_in;

    assign mul_in = itm_reg[MUL_ST-1];

    always_ff @(posedge aclk) begin
        if (ce) begin
            d_reg <= 64'(wheelbase_reg) * 64'(cc_reg);
            n_reg <= 61'(mul_in.ds) * 61'(mul_in.thm);
        end
    end

    // ------------------------------------------------------------------
    // prep stage: overflow tests and divider operands
    // gain = (ds << 46) / d, offset magnitude = (n << 18) / d;
    // either quotient reaching 2^32 saturates, so only 32 bits are divided
    // ------------------------------------------------------------------
    item_t       pr_in;
    logic        pr_dzero;
    logic        pr_govf;
    logic        pr_oovf;
    logic [63:0] den_reg;
    logic [63:0] rg_reg;
    logic [63:0] ro_reg;
    logic [31:0] lo_reg;

    assign pr_in    = itm_reg[PREP_ST-1];
    assign pr_dzero = d_reg == '0;
    assign pr_govf  = 64'({pr_in.ds, 14'd0}) >= d_reg;
    assign pr_oovf  = {17'd0, n_reg} >= {d_reg, 14'd0};

    always_ff @(posedge aclk) begin
        if (ce) begin
            den_reg <= d_reg;
            rg_reg  <= 64'({pr_in.ds, 14'd0});
            ro_reg  <= 64'(n_reg[60:14]);
            lo_reg  <= {n_reg[13:0], 18'd0};
        end
    end

    logic [31:0] qg;
    logic [31:0] qo;

    bml_divider #(
        .DW  (64),
        .QW  (32),
        .SPS (DIV_SPS)
    ) u_div_gain (
        .aclk   (aclk),
        .ce     (ce),
        .den    (den_reg),
        .rem_in (rg_reg),
        .low_in ('0),
        .quot   (qg)
    );

    bml_divider #(
        .DW  (64),
        .QW  (32),
        .SPS (DIV_SPS)
    ) u_div_off (
        .aclk   (aclk),
        .ce     (ce),
        .den    (den_reg),
        .rem_in (ro_reg),
        .low_in (lo_reg),
        .quot   (qo)
    );

    // ------------------------------------------------------------------
    // sideband pipe
    // ------------------------------------------------------------------
    always_comb begin
        itm_next[0]       = '0;
        itm_next[0].neg   = cu[31];
        itm_next[0].ds    = s_tdata[63:32];
        for (int k = 1; k < OUT_ST; k++) begin
            itm_next[k] = itm_reg[k-1];
        end
        itm_next[NORM_ST].azero  = prod_reg == '0;
        itm_next[CLAMP_ST].raw   = cl_raw;
        itm_next[CLAMP_ST].th    = cl_th;
        itm_next[CLAMP_ST].thm   = cl_thm;
        itm_next[CLAMP_ST].flag  = cl_flag;
        itm_next[PREP_ST].dzero  = pr_dzero;
        itm_next[PREP_ST].govf   = pr_govf;
        itm_next[PREP_ST].oovf   = pr_oovf;
        itm_next[PREP_ST].nnz    = n_reg != '0;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < OUT_ST; k++) begin
                itm_reg[k] <= itm_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // output stage: saturation, zero denominator, offset sign
    // offset is positive only for a negative curvature with a nonzero angle
    // ------------------------------------------------------------------
    item_t        fin;
    logic         pos;
    logic [31:0]  lim;
    logic [31:0]  gain;
    logic [31:0]  mag;
    logic [31:0]  offs;
    logic [127:0] m_data_reg;
    logic         m_user_reg;

    assign fin = itm_reg[OUT_ST-1];
    assign pos = fin.neg && (fin.thm != '0);
    assign lim = pos ? 32'h7FFF_FFFF : 32'h8000_0000;

    always_comb begin
        if (fin.dzero) begin
            gain = (fin.ds != '0) ? 32'hFFFF_FFFF : 32'd0;
            mag  = fin.nnz ? lim : 32'd0;
        end else begin
            gain = fin.govf ? 32'hFFFF_FFFF : qg;
            mag  = (fin.oovf || qo > lim) ? lim : qo;
        end
        offs = pos ? mag : (32'd0 - mag);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_data_reg <= {4'd0, offs, gain, fin.th, fin.raw};
            m_user_reg <= fin.flag;
        end
    end

    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

endmodule

`default_nettype wire

FILE: tb/sv/tb_bicycle_model_linearizer_top.sv
// self-checking testbench for bicycle_model_linearizer_top: drives curvature and step
// length beats, predicts each result with a bit-accurate integer model and compares it
// depends on bml_pkg and the design sources
`timescale 1ns / 1ps

module tb_bicycle_model_linearizer_top
    import bml_pkg::*;
();

    localparam int PIPE_LATENCY = 51;
    localparam int WATCHDOG_LIMIT = 20000;

    // result fields of one beat
    typedef struct packed {
        logic [29:0] steer_raw;
        logic [29:0] steer_clamped;
        logic        clamped;
        logic [31:0] gain;
        logic [31:0] offset;
    } linearization_t;

    logic         aclk;
    logic         aresetn;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;   // curvature[31:0], step_length[63:32]
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;   // raw[29:0], clamped[59:30], gain[91:60], offset[123:92]
    logic [0:0]   m_tuser;   // was_clamped[0]

    // model copy of the two registers
    logic [31:0] wheelbase_q824;
    logic [28:0] limit_q428;

    linearization_t expected_q[$];
    int  mismatches;
    bit  timed_out;
    bit  idle_enable;     // random idling on both sides
    int  hold_cycles;     // pending long receiver hold-off
    int  quiet_cycles;

    bicycle_model_linearizer_top dut (.*);

    // clock, 2 ns period
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    // arctangent of a nonnegative q12.52 product, q4.28
    function automatic longint atan_of_product(logic [63:0] a);
        logic [63:0] ux, uy;
        longint x, y, z, nx, ny;
        ux = 64'd1 << 52;
        uy = a;
        z = 0;
        if (a == 0) return 0;
        while (ux >= (64'd1 << 60) || uy >= (64'd1 << 60)) begin
            ux >>= 1;
            uy >>= 1;
        end
        while (ux < (64'd1 << 59) && uy < (64'd1 << 59)) begin
            ux <<= 1;
            uy <<= 1;
        end
        x = longint'(ux);
        y = longint'(uy);
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (y >= 0) begin
                nx = x + shr_floor(y, i);
                ny = y - shr_floor(x, i);
                z += longint'(atan_q28(i));
            end else begin
                nx = x - shr_floor(y, i);
                ny = y + shr_floor(x, i);
                z -= longint'(atan_q28(i));
            end
            x = nx;
            y = ny;
        end
        if (z < 0) z = 0;
        if (z > longint'(HALF_PI_Q28)) z = longint'(HALF_PI_Q28);
        return z;
    endfunction

    // cosine of a q4.28 angle, q2.30
    function automatic longint cosine_q30(longint z);
        longint x, y, nx, ny;
        x = longint'(INV_GAIN_Q30);
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - shr_floor(y, i);
                ny = y + shr_floor(x, i);
                z -= longint'(atan_q28(i));
            end else begin
                nx = x + shr_floor(y, i);
                ny = y - shr_floor(x, i);
                z += longint'(atan_q28(i));
            end
            x = nx;
            y = ny;
        end
        return x;
    endfunction

    // floor(num/den) saturated to cap, den nonzero
    function automatic logic [63:0] quotient_sat(logic [127:0] num, logic [63:0] den,
                                                 logic [63:0] cap);
        logic [127:0] q;
        q = num / {64'd0, den};
        return (q > {64'd0, cap}) ? cap : q[63:0];
    endfunction

    function automatic linearization_t linearize(logic [31:0] curv, logic [31:0] step);
        linearization_t r;
        logic         neg, sat_flag, pos;
        logic [31:0]  cmag;
        longint       z, raw, thm, th, c;
        logic [63:0]  cm, den, gain, num, mag, cap;
        neg = curv[31];
        cmag = neg ? (32'd0 - curv) : curv;
        z = atan_of_product({32'd0, wheelbase_q824} * {32'd0, cmag});
        raw = neg ? -z : z;
        sat_flag = (z >= longint'(limit_q428));
        thm = sat_flag ? longint'(limit_q428) : z;
        th = neg ? -thm : thm;
        c = cosine_q30(th);
        cm = (c < 0) ? -c : c;
        den = {32'd0, wheelbase_q824} * ((cm * cm) >> 30);
        pos = neg && (thm > 0);
        // gain numerator is step scaled by 2^46
        if (den == 0) gain = (step != 0) ? 64'hFFFF_FFFF : 64'd0;
        else gain = quotient_sat({50'd0, step, 46'd0}, den, 64'hFFFF_FFFF);
        num = {32'd0, step} * thm;
        cap = pos ? 64'h7FFF_FFFF : 64'h8000_0000;
        if (den == 0) mag = (num != 0) ? cap : 64'd0;
        else mag = quotient_sat({46'd0, num, 18'd0}, den, cap);
        r.steer_raw = raw[29:0];
        r.steer_clamped = th[29:0];
        r.clamped = sat_flag;
        r.gain = gain[31:0];
        r.offset = pos ? mag[31:0] : (32'd0 - mag[31:0]);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic random_pause();
        if (idle_enable && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
    endtask

    task automatic apb_write(logic reg_idx, logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_WHEELBASE) wheelbase_q824 = value;
        else limit_q428 = value[28:0];
    endtask

    // one beat; the prediction is queued at acceptance
    // tvalid stays high until a pause or a drain drops it
    task automatic send_point(logic [31:0] curv, logic [31:0] step);
        random_pause();
        s_tvalid <= 1'b1;
        s_tdata  <= {step, curv};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_q.push_back(linearize(curv, step));
    endtask

    // pipeline has no stateless side effects, so draining the queue plus latency suffices
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 4) @(posedge aclk);
    endtask

    function automatic logic [31:0] random_curvature();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 32'h0040_0000) ^ ({32{$urandom_range(0, 1) == 1}});
            2: return $urandom_range(0, 32'h0400_0000) * ($urandom_range(0, 1) ? 1 : -1);
            default: return $urandom_range(0, 32'h0010_0000) * ($urandom_range(0, 1) ? 1 : -1);
        endcase
    endfunction

    function automatic logic [31:0] random_step();
        case ($urandom_range(0, 2))
            0: return $urandom();
            1: return $urandom_range(0, 32'h0400_0000);
            default: return $urandom_range(0, 32'h00FF_FFFF);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_field_extremes();
        logic [31:0] curvs [8] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                   32'h8000_0000, 32'h1000_0000, 32'hF000_0000, 32'h0200_0000};
        foreach (curvs[i]) send_point(curvs[i], (i % 2) ? 32'hFFFF_FFFF : 32'h0100_0000);
        send_point(32'h0100_0000, 32'd0);
        send_point(32'hFF00_0000, 32'd1);
        send_point(32'h5555_5555, 32'hAAAA_AAAA);
        send_point(32'hAAAA_AAAA, 32'h5555_5555);
        drain();
    endtask

    // clamp boundaries, zero limit and a wheelbase that drives the denominator to zero
    task automatic test_clamp_cases();
        apb_write(REG_STEER_LIMIT, 32'd0);
        send_point(32'd0, 32'h0100_0000);
        send_point(32'h0080_0000, 32'h0100_0000);
        send_point(32'hFF80_0000, 32'hFFFF_FFFF);
        drain();
        // a limit of 1.2 rad with the maximum wheelbase
        apb_write(REG_STEER_LIMIT, 32'd322122547);
        apb_write(REG_WHEELBASE, 32'hFFFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h0100_0000);
        send_point(32'h8000_0000, 32'hFFFF_FFFF);
        send_point(32'h0000_0010, 32'h0100_0000);
        drain();
        // zero wheelbase so the denominator is zero, limit above a quarter turn
        apb_write(REG_WHEELBASE, 32'd0);
        apb_write(REG_STEER_LIMIT, 32'h1FFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_point(32'h8000_0000, 32'd5);
        send_point(32'd0, 32'd0);
        send_point(32'd0, 32'd7);
        drain();
    endtask

    task automatic test_random_settings(int beats);
        logic [31:0] wb_values [4] = '{32'd1677722, 32'hFFFF_FFFF, WHEELBASE_RST, 32'h0300_0000};
        logic [31:0] lim_values [4] = '{32'd322122547, 32'd0, STEER_LIMIT_RST, 32'h0800_0000};
        for (int p = 0; p < 4; p++) begin
            apb_write(REG_WHEELBASE, (p == 3) ? $urandom() : wb_values[p]);
            apb_write(REG_STEER_LIMIT, lim_values[p]);
            for (int n = 0; n < beats; n++) send_point(random_curvature(), random_step());
            drain();
        end
    endtask

    // receiver holds off long enough to fill the pipe while the sender keeps offering
    task automatic test_back_pressure();
        hold_cycles = 6 * PIPE_LATENCY;
        for (int n = 0; n < 150; n++) send_point(random_curvature(), random_step());
        drain();
    endtask

    // ------------------------------------------------------------------
    // receiver: stalls and checking
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (idle_enable && !m_tready) begin
            m_tready <= ($urandom_range(0, 3) == 0);
        end else if (idle_enable && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        linearization_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.steer_raw     = m_tdata[29:0];
            got.steer_clamped = m_tdata[59:30];
            got.clamped       = m_tuser[0];
            got.gain          = m_tdata[91:60];
            got.offset        = m_tdata[123:92];
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: raw %h/%h clamp %h/%h flag %b/%b gain %h/%h off %h/%h",
                                 want.steer_raw, got.steer_raw, want.steer_clamped,
                                 got.steer_clamped, want.clamped, got.clamped,
                                 want.gain, got.gain, want.offset, got.offset);
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat or apb access
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            timed_out = 1'b1;
            $display("tb_bicycle_model_linearizer_top failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        mismatches  = 0;
        timed_out   = 1'b0;
        hold_cycles = 0;
        quiet_cycles = 0;
        idle_enable = 1'b1;
        wheelbase_q824 = WHEELBASE_RST;
        limit_q428     = STEER_LIMIT_RST;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_field_extremes();
        test_clamp_cases();
        test_back_pressure();
        test_random_settings(300);
        // last part with no idling on either side
        idle_enable = 1'b0;
        test_random_settings(60);

        if (mismatches == 0 && !timed_out)
            $display("tb_bicycle_model_linearizer_top passed");
        else
            $display("tb_bicycle_model_linearizer_top failed");
        $finish;
    end

endmodule

FILE: files.f
design/bml_pkg.sv
design/bml_divider.sv
design/bicycle_model_linearizer_top.sv
tb/sv/tb_bicycle_model_linearizer_top.sv
